// ===== src/bdras_pkg.sv =====
// shared types, constants and command codes for the block decomposed range add/sum unit
// no dependencies; every other file but bdras_ram uses this package by scoped names
`timescale 1ns / 1ps

package bdras_pkg;

   // default capacities
   localparam int MAX_ELEMENTS_DEF = 1024;
   localparam int MAX_BLOCKS_DEF   = 64;

   // fixed field widths
   localparam int IDX_W  = 11;
   localparam int VAL_W  = 64;
   localparam int DIV_W  = 12;
   localparam int DCNT_W = 4;
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;

   // request kinds
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_ADD   = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   // register indexes
   localparam logic REG_COUNT = 1'b0;
   localparam logic REG_SIZE  = 1'b1;

   // datapath commands
   localparam logic [4:0] CMD_NOP       = 5'd0;
   localparam logic [4:0] CMD_CLR_START = 5'd1;
   localparam logic [4:0] CMD_CLR_STEP  = 5'd2;
   localparam logic [4:0] CMD_LATCH     = 5'd3;
   localparam logic [4:0] CMD_DIV_A     = 5'd5;
   localparam logic [4:0] CMD_DIV_Z     = 5'd6;
   localparam logic [4:0] CMD_BS_SET    = 5'd7;
   localparam logic [4:0] CMD_A_SET     = 5'd8;
   localparam logic [4:0] CMD_Z_SET     = 5'd9;
   localparam logic [4:0] CMD_LD_RD     = 5'd10;
   localparam logic [4:0] CMD_LD_RAW    = 5'd11;
   localparam logic [4:0] CMD_LD_WR     = 5'd12;
   localparam logic [4:0] CMD_SEG_FIRST = 5'd13;
   localparam logic [4:0] CMD_SEG_LAST  = 5'd14;
   localparam logic [4:0] CMD_BLK_RD    = 5'd15;
   localparam logic [4:0] CMD_EL_RD     = 5'd16;
   localparam logic [4:0] CMD_EL_WR     = 5'd17;
   localparam logic [4:0] CMD_SUM_WR    = 5'd18;
   localparam logic [4:0] CMD_MID_START = 5'd19;
   localparam logic [4:0] CMD_MID_RD    = 5'd20;
   localparam logic [4:0] CMD_MID_WR    = 5'd21;
   localparam logic [4:0] CMD_RESP      = 5'd22;

   typedef struct packed {
      logic [1:0]              req_type;
      logic [IDX_W-1:0]        left_index;
      logic [IDX_W-1:0]        right_index;
      logic signed [VAL_W-1:0] value;
   } req_type_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] range_sum;
      logic                    status;
   } rsp_type;

   typedef struct packed {
      logic [4:0] op;
      logic       first;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic bad;
      logic kind_load;
      logic kind_add;
      logic div_done;
      logic same_block;
      logic elem_last;
      logic mid_empty;
      logic slot_free;
   } stat_type;

endpackage

// ===== src/bdras_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bdras_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/bdras_div.sv =====
// restoring divider, one quotient bit per cycle
// uses bdras_pkg for widths
`timescale 1ns / 1ps

module bdras_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bdras_pkg::DIV_W-1:0] dividend,
   input  logic [bdras_pkg::IDX_W-1:0] divisor,
   output logic                        done,
   output logic [bdras_pkg::DIV_W-1:0] quotient,
   output logic [bdras_pkg::IDX_W-1:0] remainder
);

   logic [bdras_pkg::DIV_W-1:0]  rem_ff, rem_in;
   logic [bdras_pkg::DIV_W-1:0]  quo_ff, quo_in;
   logic [bdras_pkg::IDX_W-1:0]  dsr_ff, dsr_in;
   logic [bdras_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [bdras_pkg::DIV_W-1:0]  trial;

   // operand load on start, else one shift and subtract step
   always_comb begin
      trial   = {rem_ff[bdras_pkg::DIV_W-2:0], quo_ff[bdras_pkg::DIV_W-1]};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quo_in = {quo_ff[bdras_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[bdras_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == bdras_pkg::DCNT_W'(bdras_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[bdras_pkg::IDX_W-1:0];

endmodule

// ===== src/bdras_dpath.sv =====
// datapath: request registers, divider, element/sum/tag rams, accumulator, output register
// uses bdras_pkg, bdras_div and bdras_ram
`timescale 1ns / 1ps

module bdras_dpath #(
   parameter int MAX_ELEMENTS = bdras_pkg::MAX_ELEMENTS_DEF,
   parameter int MAX_BLOCKS   = bdras_pkg::MAX_BLOCKS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bdras_pkg::cmd_type          cmd,
   output bdras_pkg::stat_type         stat,
   input  bdras_pkg::req_type_type     req_data,
   input  logic [bdras_pkg::IDX_W-1:0] cfg_count,
   input  logic [bdras_pkg::IDX_W-1:0] cfg_size,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bdras_pkg::rsp_type          rsp_data
);

   localparam int EA_W  = $clog2(MAX_ELEMENTS);
   localparam int BA_W  = $clog2(MAX_BLOCKS);
   localparam int SWEEP = (MAX_ELEMENTS > MAX_BLOCKS) ? MAX_ELEMENTS : MAX_BLOCKS;
   localparam int CLR_W = $clog2(SWEEP);
   localparam int IW    = bdras_pkg::IDX_W;
   localparam int VW    = bdras_pkg::VAL_W;

   bdras_pkg::req_type_type req_ff;
   bdras_pkg::rsp_type      rsp_ff;
   logic                    rsp_valid_ff;
   logic [IW-1:0]           cnt_ff, bs_ff, ra_ff, rz_ff;
   logic [BA_W-1:0]         p_ff, q_ff, blk_ff, mb_ff;
   logic [EA_W-1:0]         cur_ff, end_ff;
   logic [VW-1:0]           tag_ff, sum_ff, raw_ff, res_ff, vbs_ff;
   logic [CLR_W-1:0]        clr_ff;

   logic [IW-1:0]                 a_idx, z_idx, cnt_use, bs_raw, need;
   logic [bdras_pkg::DIV_W-1:0]   end1;
   logic                          bad;
   logic [1:0]                    kind;
   logic                          div_start, div_done;
   logic [bdras_pkg::DIV_W-1:0]   div_dvd, div_quo;
   logic [IW-1:0]                 div_dsr, div_rem;
   logic                          is_add, is_query;

   logic            el_we, el_re, bk_we, sm_we, bk_re;
   logic [EA_W-1:0] el_waddr, el_raddr;
   logic [VW-1:0]   el_wdata, el_rdata, tg_wdata, tg_rdata, sm_wdata, sm_rdata;
   logic [BA_W-1:0] bk_waddr, bk_raddr;
   logic            tg_we;

   // request decode and range check
   assign kind     = req_ff.req_type;
   assign a_idx    = req_ff.left_index - 1'b1;
   assign z_idx    = req_ff.right_index - 1'b1;
   assign is_add   = (kind == bdras_pkg::REQ_ADD);
   assign is_query = (kind == bdras_pkg::REQ_QUERY);
   assign cnt_use  = (32'(cfg_count) > MAX_ELEMENTS) ? IW'(MAX_ELEMENTS) : cfg_count;
   assign bs_raw   = (cfg_size == '0) ? IW'(1) : cfg_size;
   // smallest block size that fits the blocks in the stores; block count is a power of two
   assign need     = IW'(({1'b0, cnt_ff} + bdras_pkg::DIV_W'(MAX_BLOCKS - 1)) >> BA_W);
   assign end1     = (p_ff == q_ff) ? {1'b0, z_idx}
                   : ({1'b0, a_idx} - {1'b0, ra_ff} + {1'b0, bs_ff} - 1'b1);

   always_comb begin
      case (kind)
         bdras_pkg::REQ_LOAD: begin
            bad = (req_ff.left_index == '0) || (req_ff.left_index > cnt_ff);
         end
         bdras_pkg::REQ_ADD, bdras_pkg::REQ_QUERY: begin
            bad = (req_ff.left_index == '0) || (req_ff.right_index > cnt_ff)
               || (req_ff.left_index > req_ff.right_index);
         end
         default: begin
            bad = 1'b1;
         end
      endcase
   end

   // shared divider for left and right block numbers
   always_comb begin
      div_start = 1'b0;
      div_dvd   = {1'b0, a_idx};
      div_dsr   = bs_ff;
      case (cmd.op)
         bdras_pkg::CMD_DIV_A: begin
            div_start = 1'b1;
         end
         bdras_pkg::CMD_DIV_Z: begin
            div_start = 1'b1;
            div_dvd   = {1'b0, z_idx};
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   bdras_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // ram port steering
   always_comb begin
      el_we    = 1'b0;
      el_re    = 1'b0;
      el_waddr = cur_ff;
      el_raddr = cur_ff;
      el_wdata = el_rdata + req_ff.value;
      bk_we    = 1'b0;
      tg_we    = 1'b0;
      sm_we    = 1'b0;
      bk_re    = 1'b0;
      bk_waddr = blk_ff;
      bk_raddr = blk_ff;
      tg_wdata = tg_rdata + req_ff.value;
      sm_wdata = sum_ff;
      case (cmd.op)
         bdras_pkg::CMD_CLR_STEP: begin
            el_we    = (32'(clr_ff) < MAX_ELEMENTS);
            bk_we    = (32'(clr_ff) < MAX_BLOCKS);
            tg_we    = bk_we;
            sm_we    = bk_we;
            el_waddr = EA_W'(clr_ff);
            bk_waddr = BA_W'(clr_ff);
            el_wdata = '0;
            tg_wdata = '0;
            sm_wdata = '0;
         end
         bdras_pkg::CMD_LD_RD: begin
            el_re    = 1'b1;
            el_raddr = EA_W'(a_idx);
            bk_re    = 1'b1;
            bk_raddr = p_ff;
         end
         bdras_pkg::CMD_LD_WR: begin
            el_we    = 1'b1;
            el_waddr = EA_W'(a_idx);
            el_wdata = raw_ff;
            sm_we    = 1'b1;
            bk_waddr = p_ff;
            sm_wdata = sm_rdata + raw_ff - el_rdata;
         end
         bdras_pkg::CMD_BLK_RD: begin
            bk_re = 1'b1;
         end
         bdras_pkg::CMD_EL_RD: begin
            el_re = 1'b1;
         end
         bdras_pkg::CMD_EL_WR: begin
            el_we = is_add;
         end
         bdras_pkg::CMD_SUM_WR: begin
            sm_we = is_add;
         end
         bdras_pkg::CMD_MID_RD: begin
            bk_re    = 1'b1;
            bk_raddr = mb_ff;
         end
         bdras_pkg::CMD_MID_WR: begin
            tg_we    = is_add;
            sm_we    = is_add;
            bk_waddr = mb_ff;
            sm_wdata = sm_rdata + vbs_ff;
         end
         default: begin
            el_we = 1'b0;
         end
      endcase
   end

   bdras_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
      .clock (clock),
      .we    (el_we),
      .waddr (el_waddr),
      .wdata (el_wdata),
      .re    (el_re),
      .raddr (el_raddr),
      .rdata (el_rdata)
   );

   bdras_ram #(.WIDTH(VW), .DEPTH(MAX_BLOCKS)) u_tag_ram (
      .clock (clock),
      .we    (tg_we),
      .waddr (bk_waddr),
      .wdata (tg_wdata),
      .re    (bk_re),
      .raddr (bk_raddr),
      .rdata (tg_rdata)
   );

   bdras_ram #(.WIDTH(VW), .DEPTH(MAX_BLOCKS)) u_sum_ram (
      .clock (clock),
      .we    (sm_we),
      .waddr (bk_waddr),
      .wdata (sm_wdata),
      .re    (bk_re),
      .raddr (bk_raddr),
      .rdata (sm_rdata)
   );

   // working registers
   always_ff @(posedge clock) begin
      vbs_ff <= VW'(req_ff.value * bs_ff);
      case (cmd.op)
         bdras_pkg::CMD_LATCH: begin
            req_ff <= req_data;
            cnt_ff <= cnt_use;
            res_ff <= '0;
         end
         bdras_pkg::CMD_BS_SET: begin
            bs_ff <= (bs_raw < need) ? need : bs_raw;
         end
         bdras_pkg::CMD_A_SET: begin
            p_ff  <= BA_W'(div_quo);
            ra_ff <= div_rem;
         end
         bdras_pkg::CMD_Z_SET: begin
            q_ff  <= BA_W'(div_quo);
            rz_ff <= div_rem;
         end
         bdras_pkg::CMD_LD_RAW: begin
            raw_ff <= req_ff.value - tg_rdata;
         end
         bdras_pkg::CMD_SEG_FIRST: begin
            cur_ff <= EA_W'(a_idx);
            end_ff <= EA_W'(end1);
            blk_ff <= p_ff;
         end
         bdras_pkg::CMD_SEG_LAST: begin
            cur_ff <= EA_W'(z_idx - rz_ff);
            end_ff <= EA_W'(z_idx);
            blk_ff <= q_ff;
         end
         bdras_pkg::CMD_EL_RD: begin
            if (cmd.first) begin
               tag_ff <= tg_rdata;
               sum_ff <= sm_rdata;
            end
         end
         bdras_pkg::CMD_EL_WR: begin
            if (is_add) begin
               sum_ff <= sum_ff + req_ff.value;
            end
            if (is_query) begin
               res_ff <= res_ff + el_rdata + tag_ff;
            end
            cur_ff <= cur_ff + 1'b1;
         end
         bdras_pkg::CMD_MID_START: begin
            mb_ff <= p_ff + 1'b1;
         end
         bdras_pkg::CMD_MID_WR: begin
            if (is_query) begin
               res_ff <= res_ff + sm_rdata;
            end
            mb_ff <= mb_ff + 1'b1;
         end
         default: begin
            mb_ff <= mb_ff;
         end
      endcase
   end

   // clearing sweep counter and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == bdras_pkg::CMD_CLR_START) begin
            clr_ff <= '0;
         end else if (cmd.op == bdras_pkg::CMD_CLR_STEP) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.op == bdras_pkg::CMD_RESP) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.op == bdras_pkg::CMD_RESP) begin
         rsp_ff.range_sum <= res_ff;
         rsp_ff.status    <= bad;
      end
   end

   assign stat.clr_last   = (clr_ff == CLR_W'(SWEEP - 1));
   assign stat.bad        = bad;
   assign stat.kind_load  = (kind == bdras_pkg::REQ_LOAD);
   assign stat.kind_add   = is_add;
   assign stat.div_done   = div_done;
   assign stat.same_block = (p_ff == q_ff);
   assign stat.elem_last  = (cur_ff == end_ff);
   assign stat.mid_empty  = (mb_ff == q_ff);
   assign stat.slot_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/bdras_ctrl.sv =====
// controller: sequences clearing, division, element walks and block walks
// uses bdras_pkg; drives the datapath through cmd_type and reads stat_type
`timescale 1ns / 1ps

module bdras_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                cfg_write,
   input  logic                req_valid,
   output logic                req_stall,
   output bdras_pkg::cmd_type  cmd,
   input  bdras_pkg::stat_type stat
);

   localparam logic [4:0] S_CLEAR   = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_CHECK   = 5'd2;
   localparam logic [4:0] S_DN_GO   = 5'd3;
   localparam logic [4:0] S_DA_GO   = 5'd5;
   localparam logic [4:0] S_DA_WAIT = 5'd6;
   localparam logic [4:0] S_DZ_GO   = 5'd7;
   localparam logic [4:0] S_DZ_WAIT = 5'd8;
   localparam logic [4:0] S_LD_RD   = 5'd9;
   localparam logic [4:0] S_LD_RAW  = 5'd10;
   localparam logic [4:0] S_LD_WR   = 5'd11;
   localparam logic [4:0] S_SEG     = 5'd12;
   localparam logic [4:0] S_BLK_RD  = 5'd13;
   localparam logic [4:0] S_EL_RD   = 5'd14;
   localparam logic [4:0] S_EL_WR   = 5'd15;
   localparam logic [4:0] S_SUM_WR  = 5'd16;
   localparam logic [4:0] S_MID_ST  = 5'd17;
   localparam logic [4:0] S_MID_RD  = 5'd18;
   localparam logic [4:0] S_MID_WR  = 5'd19;
   localparam logic [4:0] S_RESP    = 5'd20;

   logic [4:0] state_ff, state_in;
   logic       last_ff, last_in;
   logic       first_ff, first_in;
   logic       accepted;

   assign req_stall = (state_ff != S_IDLE) || cfg_write;
   assign accepted  = req_valid && !req_stall;

   // next state and command
   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      first_in  = first_ff;
      cmd.op    = bdras_pkg::CMD_NOP;
      cmd.first = first_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = bdras_pkg::CMD_CLR_STEP;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accepted) begin
               cmd.op   = bdras_pkg::CMD_LATCH;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = stat.bad ? S_RESP : S_DN_GO;
         end
         S_DN_GO: begin
            cmd.op   = bdras_pkg::CMD_BS_SET;
            state_in = S_DA_GO;
         end
         S_DA_GO: begin
            cmd.op   = bdras_pkg::CMD_DIV_A;
            state_in = S_DA_WAIT;
         end
         S_DA_WAIT: begin
            if (stat.div_done) begin
               cmd.op   = bdras_pkg::CMD_A_SET;
               state_in = stat.kind_load ? S_LD_RD : S_DZ_GO;
            end
         end
         S_DZ_GO: begin
            cmd.op   = bdras_pkg::CMD_DIV_Z;
            state_in = S_DZ_WAIT;
         end
         S_DZ_WAIT: begin
            if (stat.div_done) begin
               cmd.op   = bdras_pkg::CMD_Z_SET;
               last_in  = 1'b0;
               state_in = S_SEG;
            end
         end
         S_LD_RD: begin
            cmd.op   = bdras_pkg::CMD_LD_RD;
            state_in = S_LD_RAW;
         end
         S_LD_RAW: begin
            cmd.op   = bdras_pkg::CMD_LD_RAW;
            state_in = S_LD_WR;
         end
         S_LD_WR: begin
            cmd.op   = bdras_pkg::CMD_LD_WR;
            state_in = S_RESP;
         end
         S_SEG: begin
            cmd.op   = last_ff ? bdras_pkg::CMD_SEG_LAST : bdras_pkg::CMD_SEG_FIRST;
            state_in = S_BLK_RD;
         end
         S_BLK_RD: begin
            cmd.op   = bdras_pkg::CMD_BLK_RD;
            first_in = 1'b1;
            state_in = S_EL_RD;
         end
         S_EL_RD: begin
            cmd.op   = bdras_pkg::CMD_EL_RD;
            first_in = 1'b0;
            state_in = S_EL_WR;
         end
         S_EL_WR: begin
            cmd.op   = bdras_pkg::CMD_EL_WR;
            state_in = stat.elem_last ? S_SUM_WR : S_EL_RD;
         end
         S_SUM_WR: begin
            cmd.op   = bdras_pkg::CMD_SUM_WR;
            state_in = (last_ff || stat.same_block) ? S_RESP : S_MID_ST;
         end
         S_MID_ST: begin
            cmd.op   = bdras_pkg::CMD_MID_START;
            state_in = S_MID_RD;
         end
         S_MID_RD: begin
            if (stat.mid_empty) begin
               last_in  = 1'b1;
               state_in = S_SEG;
            end else begin
               cmd.op   = bdras_pkg::CMD_MID_RD;
               state_in = S_MID_WR;
            end
         end
         S_MID_WR: begin
            cmd.op   = bdras_pkg::CMD_MID_WR;
            state_in = S_MID_RD;
         end
         S_RESP: begin
            if (stat.slot_free) begin
               cmd.op   = bdras_pkg::CMD_RESP;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
      // a register write restarts the clearing sweep
      if (cfg_write) begin
         cmd.op   = bdras_pkg::CMD_CLR_START;
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         last_ff  <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         first_ff <= first_in;
      end
   end

   // reset always lands in the clearing sweep
   a_reset_clear : assert property (@(posedge clock) reset |=> (state_ff == S_CLEAR))
      else $error("reset did not start clearing sweep");

   // a result is never loaded over one that is still waiting
   a_resp_slot : assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bdras_pkg::CMD_RESP) |-> stat.slot_free)
      else $error("result loaded into a busy output slot");

   // an accepted transaction always goes to the range check next
   a_accept_check : assert property (@(posedge clock) disable iff (reset)
      accepted |=> (state_ff == S_CHECK))
      else $error("accepted transaction not checked");

   // divider results are only captured once the divider reports done
   a_div_capture : assert property (@(posedge clock) disable iff (reset)
      (cmd.op == bdras_pkg::CMD_A_SET || cmd.op == bdras_pkg::CMD_Z_SET)
      |-> stat.div_done)
      else $error("divider captured before done");

endmodule

// ===== src/block_decomposed_range_add_sum.sv =====
// top level: register port, controller and datapath of the range add / range sum unit
// uses bdras_pkg, bdras_ctrl and bdras_dpath
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_type_type (kind, left, right, value)
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_type (range_sum, status)
//   csr     | in        | psel/penable/pready  | count at 0x0, block size at 0x4
//
// steps after acceptance: a rejected transaction goes to the check and then the result; a load
// takes the block size, then its block number on the serial divider; a range takes the block
// size, two block numbers on the divider, check and result, plus an element walk over each
// end block and a walk over the whole blocks between them.
// reset and every register write run a clearing pass over max(MAX_ELEMENTS, MAX_BLOCKS)
// addresses through the element, sum and tag rams; requests stall meanwhile.
// one transaction at a time; the next is taken while a result waits on rsp_stall.
`timescale 1ns / 1ps

module block_decomposed_range_add_sum #(
   parameter int MAX_ELEMENTS = bdras_pkg::MAX_ELEMENTS_DEF,
   parameter int MAX_BLOCKS   = bdras_pkg::MAX_BLOCKS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bdras_pkg::req_type_type      req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bdras_pkg::rsp_type           rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bdras_pkg::ADDR_W-1:0] paddr,
   input  logic [bdras_pkg::DATA_W-1:0] pwdata,
   output logic [bdras_pkg::DATA_W-1:0] prdata,
   output logic                         pready
);

   logic [bdras_pkg::IDX_W-1:0] count_ff, size_ff;
   logic                        cfg_write;
   bdras_pkg::cmd_type          cmd;
   bdras_pkg::stat_type         stat;

   // register port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == bdras_pkg::REG_SIZE)
                    ? bdras_pkg::DATA_W'(size_ff) : bdras_pkg::DATA_W'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= bdras_pkg::IDX_W'(1);
         size_ff  <= bdras_pkg::IDX_W'(1);
      end else if (cfg_write) begin
         if (paddr[2] == bdras_pkg::REG_COUNT) begin
            count_ff <= pwdata[bdras_pkg::IDX_W-1:0];
         end else begin
            size_ff <= pwdata[bdras_pkg::IDX_W-1:0];
         end
      end
   end

   bdras_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_write (cfg_write),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   bdras_dpath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .MAX_BLOCKS   (MAX_BLOCKS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .cfg_count (count_ff),
      .cfg_size  (size_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== dv/block_decomposed_range_add_sum_chk.sv =====
// scoreboard for the range add / range sum unit: keeps its own copy of the array,
// block sums and block tags, predicts each result and compares it; uses bdras_pkg
`timescale 1ns / 1ps

module block_decomposed_range_add_sum_chk (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  bdras_pkg::req_type_type      req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  bdras_pkg::rsp_type           rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic                         pready,
   input  logic [bdras_pkg::ADDR_W-1:0] paddr,
   input  logic [bdras_pkg::DATA_W-1:0] pwdata,
   output int                           pending,
   output int                           failures
);

   localparam int CAP_ELEM = bdras_pkg::MAX_ELEMENTS_DEF;
   localparam int CAP_BLK  = bdras_pkg::MAX_BLOCKS_DEF;

   logic [63:0]        elem_mem [CAP_ELEM];
   logic [63:0]        bsum_mem [CAP_BLK];
   logic [63:0]        btag_mem [CAP_BLK];
   logic [10:0]        count_reg;
   logic [10:0]        size_reg;
   bdras_pkg::rsp_type sum_queue [$];

   function automatic void clear_array();
      for (int i = 0; i < CAP_ELEM; i++) elem_mem[i] = '0;
      for (int i = 0; i < CAP_BLK; i++) begin
         bsum_mem[i] = '0;
         btag_mem[i] = '0;
      end
   endfunction

   // apply one transaction to the model array and return its result
   function automatic bdras_pkg::rsp_type apply_request(bdras_pkg::req_type_type r);
      bdras_pkg::rsp_type res;
      int                 cnt, bs, need, a, z, p, q, e, b;
      logic [63:0]        v, acc, raw;
      cnt = (count_reg > CAP_ELEM) ? CAP_ELEM : int'(count_reg);
      bs = (size_reg == 0) ? 1 : int'(size_reg);
      need = (cnt + CAP_BLK - 1) / CAP_BLK;
      if (bs < need) bs = need;
      v = r.value;
      acc = '0;
      res.status = 1'b0;
      if (r.req_type == bdras_pkg::REQ_LOAD) begin
         if (r.left_index < 1 || r.left_index > cnt) begin
            res.status = 1'b1;
         end else begin
            e = int'(r.left_index) - 1;
            b = e / bs;
            raw = v - btag_mem[b];
            bsum_mem[b] = bsum_mem[b] + raw - elem_mem[e];
            elem_mem[e] = raw;
         end
      end else if (r.req_type == bdras_pkg::REQ_ADD || r.req_type == bdras_pkg::REQ_QUERY) begin
         if (r.left_index < 1 || r.right_index > cnt || r.left_index > r.right_index) begin
            res.status = 1'b1;
         end else begin
            a = int'(r.left_index) - 1;
            z = int'(r.right_index) - 1;
            p = a / bs;
            q = z / bs;
            for (int i = a; i <= z; i++) begin
               b = i / bs;
               if (b == p || b == q) begin
                  // partial end blocks walk element by element
                  if (r.req_type == bdras_pkg::REQ_ADD) begin
                     elem_mem[i] += v;
                     bsum_mem[b] += v;
                  end else begin
                     acc += elem_mem[i] + btag_mem[b];
                  end
               end
            end
            // whole blocks in between use tags and sums
            for (int k = p + 1; k < q; k++) begin
               if (r.req_type == bdras_pkg::REQ_ADD) begin
                  btag_mem[k] += v;
                  bsum_mem[k] += v * 64'(bs);
               end else begin
                  acc += bsum_mem[k];
               end
            end
            if (r.req_type == bdras_pkg::REQ_ADD) acc = '0;
         end
      end else begin
         res.status = 1'b1;
      end
      res.range_sum = acc;
      return res;
   endfunction

   // one process, so register writes, requests and results keep their order
   always @(posedge clock) begin
      bdras_pkg::rsp_type want;
      int                 errs;
      errs = 0;
      if (reset) begin
         count_reg <= 11'd1;
         size_reg <= 11'd1;
         clear_array();
         sum_queue.delete();
         failures <= 0;
         pending <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == bdras_pkg::REG_COUNT) count_reg <= pwdata[10:0];
            else size_reg <= pwdata[10:0];
            clear_array();
         end
         if (req_valid && !req_stall) sum_queue.push_back(apply_request(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (sum_queue.size() == 0) begin
               $error("result transaction with nothing expected");
               errs++;
            end else begin
               want = sum_queue.pop_front();
               if (rsp_data.range_sum !== want.range_sum) begin
                  $error("range_sum expected %h actual %h", want.range_sum, rsp_data.range_sum);
                  errs++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status expected %b actual %b", want.status, rsp_data.status);
                  errs++;
               end
            end
         end
         failures <= failures + errs;
         pending <= sum_queue.size();
      end
   end
endmodule

// ===== dv/block_decomposed_range_add_sum_tb.sv =====
// testbench top for the range add / range sum unit: clock, reset, register writes,
// request and result traffic and the verdict; uses bdras_pkg and the checker module
`timescale 1ns / 1ps

module block_decomposed_range_add_sum_tb;

   localparam int WATCHDOG_LIMIT = 40000;

   logic                          clock;
   logic                          reset;
   logic                          req_valid, req_stall;
   bdras_pkg::req_type_type       req_data;
   logic                          rsp_valid, rsp_stall;
   bdras_pkg::rsp_type            rsp_data;
   logic                          psel, penable, pwrite, pready;
   logic [bdras_pkg::ADDR_W-1:0]  paddr;
   logic [bdras_pkg::DATA_W-1:0]  pwdata, prdata;
   int                            pending, failures;
   int                            rsp_seen;
   int                            idle_cycles;
   int                            active_count;
   bit                            no_gaps;

   block_decomposed_range_add_sum dut (.*);

   block_decomposed_range_add_sum_chk chk (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall,
      .rsp_data, .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .pending, .failures
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // result side: random stalls, one long hold-off, a stretch with none
   initial begin
      rsp_stall = 1'b0;
      rsp_seen = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) rsp_seen++;
         if (rsp_seen == 300) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_stall <= 1'b0;
            rsp_seen++;
         end else if (rsp_seen > 600 && rsp_seen < 800) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 16);
         end
      end
   end

   // watchdog on cycles with no transaction of any kind
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic csr_write(logic idx, logic [10:0] val);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= 32'(val);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // drain, then reprogram both registers
   task automatic set_layout(logic [10:0] cnt, logic [10:0] bs);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      csr_write(bdras_pkg::REG_COUNT, cnt);
      csr_write(bdras_pkg::REG_SIZE, bs);
   endtask

   task automatic send(logic [1:0] kind, int left, int right, logic [63:0] val);
      if (!no_gaps && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{req_type: kind, left_index: 11'(left), right_index: 11'(right),
                    value: val};
      do @(posedge clock); while (req_stall);
      active_count++;
   endtask

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 64'h8000_0000_0000_0000;
         1: return 64'h7fff_ffff_ffff_ffff;
         2: return 64'($signed($urandom_range(0, 200)) - 100);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // random traffic mostly inside the active range, some bad ranges and noise
   task automatic random_phase(int cnt_used, int items, int span);
      int sel, left, right;
      for (int n = 0; n < items; n++) begin
         sel = $urandom_range(0, 99);
         no_gaps = (active_count > 700 && active_count < 900);
         if (sel < 5 || cnt_used == 0) begin
            send(2'($urandom), $urandom_range(0, 2047), $urandom_range(0, 2047), pick_value());
         end else begin
            left = $urandom_range(1, cnt_used);
            right = left + (($urandom_range(0, 9) < 8) ? $urandom_range(0, span)
                                                       : $urandom_range(0, cnt_used));
            if (right > cnt_used) right = cnt_used;
            if (sel < 9) right = left - 1;
            if (sel < 35) send(bdras_pkg::REQ_LOAD, left, 0, pick_value());
            else if (sel < 65) send(bdras_pkg::REQ_ADD, left, right, pick_value());
            else send(bdras_pkg::REQ_QUERY, left, right, pick_value());
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      active_count = 0;
      no_gaps = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset layout of a single element
      send(bdras_pkg::REQ_LOAD, 1, 0, 64'h7fff_ffff_ffff_ffff);
      send(bdras_pkg::REQ_ADD, 1, 1, 64'd1);
      send(bdras_pkg::REQ_QUERY, 1, 1, 64'd0);
      send(bdras_pkg::REQ_QUERY, 1, 2, 64'd0);

      // directed edges on a full array
      set_layout(11'd1024, 11'd32);
      send(bdras_pkg::REQ_LOAD, 1, 0, 64'h8000_0000_0000_0000);
      send(bdras_pkg::REQ_LOAD, 1024, 0, 64'h7fff_ffff_ffff_ffff);
      send(bdras_pkg::REQ_LOAD, 0, 0, 64'd5);
      send(bdras_pkg::REQ_LOAD, 1025, 0, 64'd5);
      send(bdras_pkg::REQ_LOAD, 2047, 2047, '1);
      send(bdras_pkg::REQ_ADD, 1, 1024, 64'hffff_ffff_ffff_fffd);
      send(bdras_pkg::REQ_ADD, 5, 70, 64'd9);
      send(bdras_pkg::REQ_ADD, 40, 39, 64'd9);
      send(bdras_pkg::REQ_ADD, 0, 3, 64'd9);
      send(bdras_pkg::REQ_ADD, 3, 1025, 64'd9);
      send(bdras_pkg::REQ_QUERY, 1, 1024, 64'd0);
      send(bdras_pkg::REQ_QUERY, 33, 64, 64'd0);
      send(bdras_pkg::REQ_QUERY, 30, 100, 64'd0);
      send(bdras_pkg::REQ_QUERY, 17, 17, 64'd0);
      send(2'd3, 1, 10, 64'd1);
      send(bdras_pkg::REQ_LOAD, 40, 0, 64'd123);
      send(bdras_pkg::REQ_QUERY, 1, 1024, 64'd0);

      random_phase(1024, 500, 40);
      set_layout(11'd100, 11'd10);
      random_phase(100, 300, 30);
      set_layout(11'd2047, 11'd0);
      random_phase(1024, 300, 60);
      set_layout(11'd37, 11'd2047);
      random_phase(37, 100, 37);
      set_layout(11'd1024, 11'd1024);
      random_phase(1024, 30, 20);
      set_layout(11'd0, 11'd5);
      random_phase(0, 40, 0);
      set_layout(11'd1, 11'd1);
      random_phase(1, 60, 1);

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (failures == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
